>>> src/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants of the cartridge bank mapper: bus functions,
// result targets, register decode codes and controller/datapath signals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbm_pkg;

  typedef enum logic [1:0] {
    FUNC_CPU_READ   = 2'd0,
    FUNC_CPU_WRITE  = 2'd1,
    FUNC_PPU_ACCESS = 2'd2,
    FUNC_M2_TICK    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    TGT_NONE     = 2'd0,
    TGT_WORK_RAM = 2'd1,
    TGT_PRG_ROM  = 2'd2,
    TGT_CHR_MEM  = 2'd3
  } target_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DIVIDE = 2'd1,
    ST_HOLD   = 2'd2
  } ctrl_state_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PRG_BANK_COUNT  = 2'd0;
  localparam logic [1:0] CFG_CHR_BANK_COUNT  = 2'd1;
  localparam logic [1:0] CFG_PRG_RAM_PRESENT = 2'd2;

  // Write pages, selected by address bits 15:12.
  localparam logic [3:0] PAGE_PRG_FIRST  = 4'h8;
  localparam logic [3:0] PAGE_MISC       = 4'h9;
  localparam logic [3:0] PAGE_PRG_SECOND = 4'hA;
  localparam logic [3:0] PAGE_CHR_B      = 4'hB;
  localparam logic [3:0] PAGE_CHR_C      = 4'hC;
  localparam logic [3:0] PAGE_CHR_D      = 4'hD;
  localparam logic [3:0] PAGE_CHR_E      = 4'hE;
  localparam logic [3:0] PAGE_IRQ        = 4'hF;

  // Register select within a page.
  localparam logic [1:0] SEL_MIRRORING   = 2'd0;
  localparam logic [1:0] SEL_PRG_SWAP    = 2'd2;
  localparam logic [1:0] SEL_LATCH_LOW   = 2'd0;
  localparam logic [1:0] SEL_LATCH_HIGH  = 2'd1;
  localparam logic [1:0] SEL_IRQ_CONTROL = 2'd2;
  localparam logic [1:0] SEL_IRQ_ACK     = 2'd3;

  // IRQ control bit positions.
  localparam int unsigned IRQ_BIT_ENABLE = 1;
  localparam int unsigned IRQ_BIT_CYCLE  = 2;
  localparam int unsigned IRQ_BIT_ACK_EN = 3;

  localparam int unsigned CHR_SLOTS     = 8;
  localparam int unsigned CHR_SLOT_BITS = 3;
  localparam int unsigned BANK_W        = 9;
  localparam int unsigned MEM_ADDR_W    = 21;
  localparam int unsigned PRG_FULL_W    = 22;
  localparam int unsigned DIV_STEPS     = 9;
  localparam int unsigned DIV_CNT_W     = 4;

  localparam logic [9:0] PRESCALE_RELOAD = 10'd341;
  localparam logic [9:0] PRESCALE_STEP   = 10'd3;
  localparam logic [9:0] PRESCALE_WRAP   = 10'd338;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic load_live;
    logic load_pend;
  } cbm_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } cbm_status_t;

endpackage

>>> src/cartridge_bank_mapper_with_irq.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_irq
// Bank-switching cartridge mapper with a scanline/cycle IRQ counter.
// ----------------------------------------------------------------------------
// Each request on the input channel (func_i, addr_i, data_i) is a CPU read,
// a CPU write, a PPU access or an M2 tick; it yields exactly one result on
// the output channel: handled, target, mem_addr, mirroring and irq.
// Both channels move a request when valid is high and stall is low.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i; the
// user must do so only while the block is idle, which the block does not enforce.
// Work RAM accesses, other CPU writes, ticks and unclaimed accesses go
// straight to the output register: when it is free, the result is valid the
// cycle after acceptance and a new request can be taken every cycle.
// Program ROM reads and character accesses take the bank modulo the bank
// count, worked out one bit per cycle by the remainder unit in the datapath;
// the input stalls while it works, and the result passes through the pending
// register into the output register, after which the next request is taken.
// While the receiver stalls, the result holds in the output register; one
// further request is taken and parked, then the input stalls.
// Reset puts the mapper registers and the configuration at their power-up
// values and empties the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cartridge_bank_mapper_with_irq #(
  parameter int unsigned PRG_ADDR_BITS = 21
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        handled_o,
  output logic [1:0]  target_o,
  output logic [20:0] mem_addr_o,
  output logic [1:0]  mirroring_o,
  output logic        irq_o
);
  import cbm_pkg::*;

  cbm_cmd_t    cmd;
  cbm_status_t status;

  cbm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cbm_datapath #(
    .PRG_ADDR_BITS (PRG_ADDR_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .func_i      (func_i),
    .addr_i      (addr_i),
    .data_i      (data_i),
    .handled_o   (handled_o),
    .target_o    (target_o),
    .mem_addr_o  (mem_addr_o),
    .mirroring_o (mirroring_o),
    .irq_o       (irq_o)
  );

endmodule

>>> src/cbm_ctrl.sv
// ----------------------------------------------------------------------------
// cbm_ctrl
// Controller of the bank mapper: request handshake, sequencing of the
// bank remainder iterations and the output register's valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  cbm_pkg::cbm_status_t status_i,
  output cbm_pkg::cbm_cmd_t   cmd_o
);
  import cbm_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  logic        accept;

  // The output register can take a result when empty or being emptied.
  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (status_i.need_div) begin
            state_d = ST_DIVIDE;
          end else if (!out_free) begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_DIVIDE: begin
        if (status_i.div_last) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.accept = accept;
    case (state_q)
      ST_IDLE:   cmd_o.load_live = accept && !status_i.need_div && out_free;
      ST_DIVIDE: cmd_o.div_step  = 1'b1;
      ST_HOLD:   cmd_o.load_pend = out_free;
      default:   cmd_o = '0;
    endcase
  end

  assign out_valid_d = (cmd_o.load_live || cmd_o.load_pend) ? 1'b1
                                                            : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> src/cbm_datapath.sv
// ----------------------------------------------------------------------------
// cbm_datapath
// Datapath of the bank mapper: configuration and mapper registers, write
// decode, IRQ prescaler and counter, address translation, a shift-subtract
// remainder unit for the bank modulo, and the pending and output registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbm_datapath #(
  parameter int unsigned PRG_ADDR_BITS = 21
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cbm_pkg::cbm_cmd_t    cmd_i,
  output cbm_pkg::cbm_status_t status_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [9:0]           cfg_data_i,
  input  logic [1:0]           func_i,
  input  logic [15:0]          addr_i,
  input  logic [7:0]           data_i,
  output logic                 handled_o,
  output logic [1:0]           target_o,
  output logic [20:0]          mem_addr_o,
  output logic [1:0]           mirroring_o,
  output logic                 irq_o
);
  import cbm_pkg::*;

  localparam int unsigned PrgKeep = (PRG_ADDR_BITS < PRG_FULL_W) ? PRG_ADDR_BITS : PRG_FULL_W;
  localparam logic [PRG_FULL_W-1:0] PrgMask = PRG_FULL_W'((64'd1 << PrgKeep) - 64'd1);

  // Configuration.
  logic [8:0] prg_count_q;
  logic [9:0] chr_count_q;
  logic       ram_present_q;

  // Mapper state.
  logic [4:0] prg_first_q, prg_first_d;
  logic [4:0] prg_second_q, prg_second_d;
  logic       prg_swap_q, prg_swap_d;
  logic [3:0] chr_low_q [CHR_SLOTS];
  logic [3:0] chr_low_d [CHR_SLOTS];
  logic [4:0] chr_high_q [CHR_SLOTS];
  logic [4:0] chr_high_d [CHR_SLOTS];
  logic [1:0] mirror_q, mirror_d;
  logic [7:0] reload_q, reload_d;
  logic [7:0] irq_mode_q, irq_mode_d;
  logic [7:0] irq_count_q, irq_count_d;
  logic [9:0] presc_q, presc_d;
  logic       irq_q, irq_d;
  logic       tick_step;

  // Decode.
  logic                     ram_win;
  logic [1:0]               wsel;
  logic [3:0]               chr_page;
  logic [CHR_SLOT_BITS-1:0] chr_wslot;
  logic [CHR_SLOT_BITS-1:0] chr_rslot;
  logic [BANK_W-1:0]        second_last;
  logic [BANK_W-1:0]        prg_bank;
  logic [BANK_W-1:0]        chr_bank;

  // Result of the request as far as it is known at acceptance.
  logic              live_handled;
  target_e           live_target;
  logic [20:0]       live_maddr;
  logic              need_div;
  logic              div_is_chr;
  logic [BANK_W-1:0] div_dividend;
  logic [9:0]        div_divisor;

  // Remainder unit.
  logic [BANK_W-1:0]    dvd_q;
  logic [9:0]           dvs_q;
  logic [BANK_W-1:0]    rem_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [9:0]           rsh;
  logic [9:0]           rnext;
  logic [PRG_FULL_W-1:0] prg_full;

  // Pending result and output register.
  logic        pend_handled_q;
  target_e     pend_target_q;
  logic [20:0] pend_maddr_q;
  logic [1:0]  pend_mirror_q;
  logic        pend_irq_q;
  logic        pend_is_chr_q;
  logic [12:0] pend_low_q;
  logic        out_handled_q;
  target_e     out_target_q;
  logic [20:0] out_maddr_q;
  logic [1:0]  out_mirror_q;
  logic        out_irq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_count_q   <= 9'd32;
      chr_count_q   <= 10'd256;
      ram_present_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRG_BANK_COUNT:  prg_count_q   <= cfg_data_i[8:0];
        CFG_CHR_BANK_COUNT:  chr_count_q   <= cfg_data_i;
        CFG_PRG_RAM_PRESENT: ram_present_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign ram_win   = (addr_i[15:13] == 3'b011);
  assign wsel      = addr_i[1:0] | addr_i[3:2];
  assign chr_page  = addr_i[15:12] - PAGE_CHR_B;
  assign chr_wslot = {chr_page[1:0], wsel[1]};
  assign chr_rslot = addr_i[12:10];
  assign chr_bank  = {chr_high_q[chr_rslot], chr_low_q[chr_rslot]};

  always_comb begin
    second_last = (prg_count_q >= 9'd2) ? (prg_count_q - 9'd2) : '0;
    case (addr_i[14:13])
      2'd0:    prg_bank = prg_swap_q ? second_last : {4'd0, prg_first_q};
      2'd1:    prg_bank = {4'd0, prg_second_q};
      2'd2:    prg_bank = prg_swap_q ? {4'd0, prg_first_q} : second_last;
      default: prg_bank = prg_count_q - 9'd1;
    endcase
  end

  always_comb begin
    live_handled = 1'b0;
    live_target  = TGT_NONE;
    live_maddr   = '0;
    need_div     = 1'b0;
    div_is_chr   = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (func_e'(func_i))
      FUNC_CPU_READ: begin
        if (ram_win) begin
          live_handled = 1'b1;
          if (ram_present_q) begin
            live_target = TGT_WORK_RAM;
            live_maddr  = {8'd0, addr_i[12:0]};
          end
        end else if (addr_i[15]) begin
          live_handled = 1'b1;
          if (prg_count_q != '0) begin
            live_target  = TGT_PRG_ROM;
            need_div     = 1'b1;
            div_dividend = prg_bank;
            div_divisor  = {1'b0, prg_count_q};
          end
        end
      end
      FUNC_CPU_WRITE: begin
        if (ram_win && ram_present_q) begin
          live_target = TGT_WORK_RAM;
          live_maddr  = {8'd0, addr_i[12:0]};
        end
      end
      FUNC_PPU_ACCESS: begin
        if ((addr_i[15:13] == 3'b000) && (chr_count_q != '0)) begin
          live_handled = 1'b1;
          live_target  = TGT_CHR_MEM;
          need_div     = 1'b1;
          div_is_chr   = 1'b1;
          div_dividend = chr_bank;
          div_divisor  = chr_count_q;
        end
      end
      default: ;
    endcase
  end

  // Mapper register updates take effect when the request is accepted.
  always_comb begin
    prg_first_d  = prg_first_q;
    prg_second_d = prg_second_q;
    prg_swap_d   = prg_swap_q;
    chr_low_d    = chr_low_q;
    chr_high_d   = chr_high_q;
    mirror_d     = mirror_q;
    reload_d     = reload_q;
    irq_mode_d   = irq_mode_q;
    irq_count_d  = irq_count_q;
    presc_d      = presc_q;
    irq_d        = irq_q;
    tick_step    = 1'b0;
    if (cmd_i.accept) begin
      case (func_e'(func_i))
        FUNC_CPU_WRITE: begin
          if (!ram_win) begin
            case (addr_i[15:12])
              PAGE_PRG_FIRST:  prg_first_d = data_i[4:0];
              PAGE_MISC: begin
                if (wsel == SEL_MIRRORING) begin
                  mirror_d = data_i[1:0];
                end else if (wsel == SEL_PRG_SWAP) begin
                  prg_swap_d = data_i[1];
                end
              end
              PAGE_PRG_SECOND: prg_second_d = data_i[4:0];
              PAGE_CHR_B, PAGE_CHR_C, PAGE_CHR_D, PAGE_CHR_E: begin
                if (wsel[0]) begin
                  chr_high_d[chr_wslot] = data_i[4:0];
                end else begin
                  chr_low_d[chr_wslot] = data_i[3:0];
                end
              end
              PAGE_IRQ: begin
                case (wsel)
                  SEL_LATCH_LOW:  reload_d = {reload_q[7:4], data_i[3:0]};
                  SEL_LATCH_HIGH: reload_d = {data_i[3:0], reload_q[3:0]};
                  SEL_IRQ_CONTROL: begin
                    irq_mode_d = data_i;
                    if (data_i[IRQ_BIT_ENABLE]) begin
                      irq_count_d = reload_q;
                      presc_d     = PRESCALE_RELOAD;
                    end
                    irq_d = 1'b0;
                  end
                  default: begin
                    irq_d = 1'b0;
                    irq_mode_d[IRQ_BIT_ENABLE] = irq_mode_q[IRQ_BIT_ACK_EN];
                  end
                endcase
              end
              default: ;
            endcase
          end
        end
        FUNC_M2_TICK: begin
          if (irq_mode_q[IRQ_BIT_ENABLE]) begin
            if (irq_mode_q[IRQ_BIT_CYCLE]) begin
              tick_step = 1'b1;
            end else if (presc_q <= PRESCALE_STEP) begin
              // Dropping to zero or below wraps by one scanline.
              presc_d   = presc_q + PRESCALE_WRAP;
              tick_step = 1'b1;
            end else begin
              presc_d = presc_q - PRESCALE_STEP;
            end
            if (tick_step) begin
              if (irq_count_q == 8'hFF) begin
                irq_count_d = reload_q;
                irq_d       = 1'b1;
              end else begin
                irq_count_d = irq_count_q + 8'd1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_first_q  <= 5'd0;
      prg_second_q <= 5'd1;
      prg_swap_q   <= 1'b0;
      for (int i = 0; i < CHR_SLOTS; i++) begin
        chr_low_q[i]  <= '0;
        chr_high_q[i] <= '0;
      end
      mirror_q    <= '0;
      reload_q    <= '0;
      irq_mode_q  <= '0;
      irq_count_q <= '0;
      presc_q     <= PRESCALE_RELOAD;
      irq_q       <= 1'b0;
    end else begin
      prg_first_q  <= prg_first_d;
      prg_second_q <= prg_second_d;
      prg_swap_q   <= prg_swap_d;
      chr_low_q    <= chr_low_d;
      chr_high_q   <= chr_high_d;
      mirror_q     <= mirror_d;
      reload_q     <= reload_d;
      irq_mode_q   <= irq_mode_d;
      irq_count_q  <= irq_count_d;
      presc_q      <= presc_d;
      irq_q        <= irq_d;
    end
  end

  // One remainder bit per cycle: shift in the next dividend bit and
  // subtract the bank count when it fits.
  assign rsh   = {rem_q, dvd_q[BANK_W-1]};
  assign rnext = (rsh >= dvs_q) ? (rsh - dvs_q) : rsh;
  assign prg_full = {rnext[BANK_W-1:0], pend_low_q} & PrgMask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.accept && need_div) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pend_handled_q <= live_handled;
      pend_target_q  <= live_target;
      pend_maddr_q   <= live_maddr;
      pend_mirror_q  <= mirror_d;
      pend_irq_q     <= irq_d;
      pend_is_chr_q  <= div_is_chr;
      pend_low_q     <= addr_i[12:0];
      dvd_q          <= div_dividend;
      dvs_q          <= div_divisor;
      rem_q          <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[BANK_W-2:0], 1'b0};
      rem_q <= rnext[BANK_W-1:0];
      // The last step leaves the final offset here.
      if (pend_is_chr_q) begin
        pend_maddr_q <= {2'd0, rnext[BANK_W-1:0], pend_low_q[9:0]};
      end else begin
        pend_maddr_q <= prg_full[MEM_ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_live) begin
      out_handled_q <= live_handled;
      out_target_q  <= live_target;
      out_maddr_q   <= live_maddr;
      out_mirror_q  <= mirror_d;
      out_irq_q     <= irq_d;
    end else if (cmd_i.load_pend) begin
      out_handled_q <= pend_handled_q;
      out_target_q  <= pend_target_q;
      out_maddr_q   <= pend_maddr_q;
      out_mirror_q  <= pend_mirror_q;
      out_irq_q     <= pend_irq_q;
    end
  end

  assign status_o.need_div = need_div;
  assign status_o.div_last = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

  assign handled_o   = out_handled_q;
  assign target_o    = out_target_q;
  assign mem_addr_o  = out_maddr_q;
  assign mirroring_o = out_mirror_q;
  assign irq_o       = out_irq_q;

endmodule

>>> src/cbm_checker.sv
// ----------------------------------------------------------------------------
// cbm_port_checks
// Port-level checks of the bank mapper, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbm_port_checks (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        handled_o,
  input logic [1:0]  target_o,
  input logic [20:0] mem_addr_o
);
  import cbm_pkg::*;

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(mem_addr_o))
    else $error("stalled result changed");

  // ROM and character targets only come from claimed accesses.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (target_o == TGT_PRG_ROM || target_o == TGT_CHR_MEM) |-> handled_o)
    else $error("memory target on an unclaimed request");

  // No target means a zero offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (target_o == TGT_NONE) |-> (mem_addr_o == '0))
    else $error("offset given without a target");

  // A request taken while the result is held up is parked and the input stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && out_valid_o && out_stall_i |=> in_stall_o)
    else $error("input not stalled with a parked request");

endmodule

bind cartridge_bank_mapper_with_irq cbm_port_checks u_cbm_port_checks (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .handled_o   (handled_o),
  .target_o    (target_o),
  .mem_addr_o  (mem_addr_o)
);

>>> tb/cbm_checker.sv
// ----------------------------------------------------------------------------
// cbm_checker
// Watches both channels of the cartridge bank mapper, works out the result
// of every accepted request from its own copy of the mapper state and
// compares each delivered result with the oldest one still outstanding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbm_checker #(
  parameter int unsigned PRG_ADDR_BITS = 21
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  func_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        handled_i,
  input  logic [1:0]  target_i,
  input  logic [20:0] mem_addr_i,
  input  logic [1:0]  mirroring_i,
  input  logic        irq_i,
  output int          fail_count_o,
  output int          pending_o
);

  import cbm_pkg::*;

  localparam int unsigned PRG_MASK = (1 << PRG_ADDR_BITS) - 1;

  typedef struct packed {
    logic        handled;
    target_e     target;
    logic [20:0] mem_addr;
    logic [1:0]  mirroring;
    logic        irq;
  } map_result_t;

  map_result_t expected_q[$];
  int          fail_cnt;
  int          pending_cnt;

  // Configuration copy.
  int unsigned prg_banks;
  int unsigned chr_banks;
  logic        ram_present;

  // Mapper state copy.
  logic [4:0] prg_first;
  logic [4:0] prg_second;
  logic       swap_mode;
  logic [3:0] chr_lo [CHR_SLOTS];
  logic [4:0] chr_hi [CHR_SLOTS];
  logic [1:0] mirror_mode;
  logic [7:0] irq_reload;
  logic [7:0] irq_mode;
  logic [7:0] irq_cnt;
  logic [9:0] prescaler;
  logic       irq_flag;

  assign fail_count_o = fail_cnt;
  assign pending_o    = pending_cnt;

  task automatic reset_mapper();
    prg_banks   = 32;
    chr_banks   = 256;
    ram_present = 1'b1;
    prg_first   = 5'd0;
    prg_second  = 5'd1;
    swap_mode   = 1'b0;
    for (int i = 0; i < CHR_SLOTS; i++) begin
      chr_lo[i] = 4'd0;
      chr_hi[i] = 5'd0;
    end
    mirror_mode = 2'd0;
    irq_reload  = 8'd0;
    irq_mode    = 8'd0;
    irq_cnt     = 8'd0;
    prescaler   = PRESCALE_RELOAD;
    irq_flag    = 1'b0;
  endtask

  task automatic advance_m2();
    logic bump;
    int   p;
    bump = 1'b0;
    if (irq_mode[IRQ_BIT_ENABLE]) begin
      if (irq_mode[IRQ_BIT_CYCLE]) begin
        bump = 1'b1;
      end else begin
        p = int'(prescaler) - int'(PRESCALE_STEP);
        if (p <= 0) begin
          p    = p + int'(PRESCALE_RELOAD);
          bump = 1'b1;
        end
        prescaler = p[9:0];
      end
      if (bump) begin
        if (irq_cnt == 8'hFF) begin
          irq_cnt  = irq_reload;
          irq_flag = 1'b1;
        end else begin
          irq_cnt = irq_cnt + 8'd1;
        end
      end
    end
  endtask

  task automatic write_register(input logic [15:0] addr, input logic [7:0] data);
    logic [1:0] sel;
    logic [3:0] page_off;
    logic [2:0] slot;
    // The register select ORs the two low address pairs together.
    sel      = addr[1:0] | addr[3:2];
    page_off = addr[15:12] - PAGE_CHR_B;
    slot     = {page_off[1:0], sel[1]};
    case (addr[15:12])
      PAGE_PRG_FIRST: prg_first = data[4:0];
      PAGE_MISC: begin
        if (sel == SEL_MIRRORING) mirror_mode = data[1:0];
        else if (sel == SEL_PRG_SWAP) swap_mode = data[1];
      end
      PAGE_PRG_SECOND: prg_second = data[4:0];
      PAGE_CHR_B, PAGE_CHR_C, PAGE_CHR_D, PAGE_CHR_E: begin
        if (sel[0]) chr_hi[slot] = data[4:0];
        else chr_lo[slot] = data[3:0];
      end
      PAGE_IRQ: begin
        case (sel)
          SEL_LATCH_LOW:  irq_reload[3:0] = data[3:0];
          SEL_LATCH_HIGH: irq_reload[7:4] = data[3:0];
          SEL_IRQ_CONTROL: begin
            irq_mode = data;
            if (data[IRQ_BIT_ENABLE]) begin
              irq_cnt   = irq_reload;
              prescaler = PRESCALE_RELOAD;
            end
            irq_flag = 1'b0;
          end
          default: begin
            // Acknowledge: the enable is restored from the enable-after-ack bit.
            irq_flag                 = 1'b0;
            irq_mode[IRQ_BIT_ENABLE] = irq_mode[IRQ_BIT_ACK_EN];
          end
        endcase
      end
      default: ;
    endcase
  endtask

  task automatic map_request(input logic [1:0] fn, input logic [15:0] addr,
                             input logic [7:0] data, output map_result_t res);
    int unsigned bank;
    int unsigned second_last;
    int unsigned offset;
    logic [2:0]  slot;
    res        = '0;
    res.target = TGT_NONE;
    offset     = 0;
    case (fn)
      FUNC_CPU_READ: begin
        if (addr >= 16'h6000 && addr <= 16'h7FFF) begin
          res.handled = 1'b1;
          if (ram_present) begin
            res.target = TGT_WORK_RAM;
            offset     = addr - 16'h6000;
          end
        end else if (addr >= 16'h8000) begin
          res.handled = 1'b1;
          if (prg_banks != 0) begin
            second_last = (prg_banks >= 2) ? prg_banks - 2 : 0;
            if (addr <= 16'h9FFF) bank = swap_mode ? second_last : prg_first;
            else if (addr <= 16'hBFFF) bank = prg_second;
            else if (addr <= 16'hDFFF) bank = swap_mode ? prg_first : second_last;
            else bank = prg_banks - 1;
            res.target = TGT_PRG_ROM;
            offset     = ((bank % prg_banks) * 8192 + addr[12:0]) & PRG_MASK;
          end
        end
      end
      FUNC_CPU_WRITE: begin
        if (addr >= 16'h6000 && addr <= 16'h7FFF) begin
          if (ram_present) begin
            res.target = TGT_WORK_RAM;
            offset     = addr - 16'h6000;
          end
        end else begin
          write_register(addr, data);
        end
      end
      FUNC_PPU_ACCESS: begin
        if (addr < 16'h2000 && chr_banks != 0) begin
          slot        = addr[12:10];
          bank        = {chr_hi[slot], chr_lo[slot]};
          res.handled = 1'b1;
          res.target  = TGT_CHR_MEM;
          offset      = (bank % chr_banks) * 1024 + addr[9:0];
        end
      end
      default: advance_m2();
    endcase
    res.mem_addr  = offset[20:0];
    res.mirroring = mirror_mode;
    res.irq       = irq_flag;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    map_result_t exp_r;
    map_result_t got_r;
    if (!rst_ni) begin
      reset_mapper();
      expected_q.delete();
      fail_cnt    = 0;
      pending_cnt = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PRG_BANK_COUNT:  prg_banks = cfg_data_i[8:0];
          CFG_CHR_BANK_COUNT:  chr_banks = cfg_data_i;
          CFG_PRG_RAM_PRESENT: ram_present = cfg_data_i[0];
          default: ;
        endcase
      end
      // Results leave before the request of this edge is queued.
      if (out_valid_i && !out_stall_i) begin
        got_r.handled   = handled_i;
        got_r.target    = target_e'(target_i);
        got_r.mem_addr  = mem_addr_i;
        got_r.mirroring = mirroring_i;
        got_r.irq       = irq_i;
        if (expected_q.size() == 0) begin
          if (fail_cnt < 10)
            $display("%0t: result with no request outstanding: handled=%0d target=%0d",
                     $realtime, got_r.handled, got_r.target,
                     " mem_addr=%06h mirroring=%0d irq=%0d",
                     got_r.mem_addr, got_r.mirroring, got_r.irq);
          fail_cnt++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got_r.handled !== exp_r.handled || got_r.target !== exp_r.target ||
              got_r.mem_addr !== exp_r.mem_addr || got_r.mirroring !== exp_r.mirroring ||
              got_r.irq !== exp_r.irq) begin
            if (fail_cnt < 10) begin
              $display("%0t: wrong result: expected handled=%0d target=%0d mem_addr=%06h",
                       $realtime, exp_r.handled, exp_r.target, exp_r.mem_addr,
                       " mirroring=%0d irq=%0d", exp_r.mirroring, exp_r.irq);
              $display("%0t:                  got handled=%0d target=%0d mem_addr=%06h",
                       $realtime, got_r.handled, got_r.target, got_r.mem_addr,
                       " mirroring=%0d irq=%0d", got_r.mirroring, got_r.irq);
            end
            fail_cnt++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        map_request(func_i, addr_i, data_i, exp_r);
        expected_q.push_back(exp_r);
      end
      pending_cnt = expected_q.size();
    end
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the cartridge bank mapper with a short directed list and then random
// bus traffic under several bank-count settings, with random idling on both
// sides and one long receiver hold-off; the checker beside the block judges
// every result and this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  import cbm_pkg::*;

  localparam int unsigned PRG_ADDR_BITS  = 21;
  localparam int          PHASES         = 6;
  localparam int          PHASE_REQUESTS = 300;
  localparam int          HOLD_CYCLES    = 200;
  localparam int          SETTLE_CYCLES  = 20;
  localparam int          WATCHDOG_LIMIT = 3000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [9:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  func_i;
  logic [15:0] addr_i;
  logic [7:0]  data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        handled_o;
  logic [1:0]  target_o;
  logic [20:0] mem_addr_o;
  logic [1:0]  mirroring_o;
  logic        irq_o;

  int   fail_count;
  int   pending;
  int   sent_cnt  = 0;
  int   phase_end = 0;
  logic calm      = 1'b0;
  logic hold_req  = 1'b0;

  cartridge_bank_mapper_with_irq #(
    .PRG_ADDR_BITS(PRG_ADDR_BITS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .addr_i     (addr_i),
    .data_i     (data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .handled_o  (handled_o),
    .target_o   (target_o),
    .mem_addr_o (mem_addr_o),
    .mirroring_o(mirroring_o),
    .irq_o      (irq_o)
  );

  cbm_checker #(
    .PRG_ADDR_BITS(PRG_ADDR_BITS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .func_i      (func_i),
    .addr_i      (addr_i),
    .data_i      (data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .handled_i   (handled_o),
    .target_i    (target_o),
    .mem_addr_i  (mem_addr_o),
    .mirroring_i (mirroring_o),
    .irq_i       (irq_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin : receiver
    int hold_cnt;
    hold_cnt    = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cnt != 0) begin
        out_stall_i <= 1'b1;
        hold_cnt--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < 26);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        quiet = 0;
      else
        quiet++;
    end
    $display("cartridge_bank_mapper_with_irq: mismatch");
    $finish;
  end

  task automatic send_req(input logic [1:0] fn, input logic [15:0] addr,
                          input logic [7:0] data);
    while (!calm && $urandom_range(0, 99) < 26) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    func_i     <= fn;
    addr_i     <= addr;
    data_i     <= data;
    do @(posedge clk_i); while (in_stall_o);
    sent_cnt++;
  endtask

  // Registers may only change once every outstanding result has come back.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [9:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] read_addr();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'h6000 | 16'($urandom_range(0, 8191));
      default: return 16'h8000 | 16'($urandom_range(0, 32767));
    endcase
  endfunction

  function automatic logic [15:0] write_addr();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'h6000 | 16'($urandom_range(0, 8191));
      default: return 16'h8000 | 16'($urandom_range(0, 32767));
    endcase
  endfunction

  function automatic logic [15:0] ppu_addr();
    if ($urandom_range(0, 4) == 0) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, 8191));
  endfunction

  // Latch, enable, a run of ticks, then acknowledge.
  // The run of ticks is cut short once the phase has its share of requests.
  task automatic irq_sequence();
    logic [7:0]  ctrl;
    logic [15:0] page_bits;
    int          ticks;
    page_bits = 16'($urandom_range(0, 255)) << 4;
    send_req(FUNC_CPU_WRITE, PAGE_IRQ << 12 | page_bits, 8'($urandom_range(0, 255)));
    send_req(FUNC_CPU_WRITE, PAGE_IRQ << 12 | page_bits | 16'h1,
             {4'($urandom_range(0, 15)), 4'($urandom_range(14, 15))});
    ctrl = 8'($urandom_range(0, 255));
    ctrl[IRQ_BIT_ENABLE] = 1'b1;
    case ($urandom_range(0, 2))
      0:       send_req(FUNC_CPU_WRITE, PAGE_IRQ << 12 | page_bits | 16'h2, ctrl);
      1:       send_req(FUNC_CPU_WRITE, PAGE_IRQ << 12 | page_bits | 16'h8, ctrl);
      default: send_req(FUNC_CPU_WRITE, PAGE_IRQ << 12 | page_bits | 16'hA, ctrl);
    endcase
    ticks = ctrl[IRQ_BIT_CYCLE] ? $urandom_range(1, 90) : $urandom_range(100, 500);
    repeat (ticks) begin
      if (sent_cnt >= phase_end) break;
      if ($urandom_range(0, 9) == 0)
        send_req(FUNC_CPU_READ, read_addr(), 8'($urandom_range(0, 255)));
      else
        send_req(FUNC_M2_TICK, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
    end
    send_req(FUNC_CPU_WRITE,
             PAGE_IRQ << 12 | page_bits | {12'h0, 2'($urandom_range(0, 3)), 2'b11},
             8'($urandom_range(0, 255)));
  endtask

  task automatic random_request();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 2)
      irq_sequence();
    else if (pick < 33)
      send_req(FUNC_CPU_READ, read_addr(), 8'($urandom_range(0, 255)));
    else if (pick < 55)
      send_req(FUNC_CPU_WRITE, write_addr(), 8'($urandom_range(0, 255)));
    else if (pick < 75)
      send_req(FUNC_PPU_ACCESS, ppu_addr(), 8'($urandom_range(0, 255)));
    else
      send_req(FUNC_M2_TICK, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
  endtask

  task automatic directed_requests();
    send_req(FUNC_CPU_READ, 16'h0000, 8'h00);
    send_req(FUNC_CPU_READ, 16'h5FFF, 8'hFF);
    send_req(FUNC_CPU_READ, 16'h6000, 8'h00);
    send_req(FUNC_CPU_READ, 16'h7FFF, 8'h00);
    send_req(FUNC_CPU_WRITE, 16'h6ABC, 8'hFF);
    send_req(FUNC_CPU_WRITE, 16'h4020, 8'h5A);
    send_req(FUNC_CPU_READ, 16'h8000, 8'h00);
    send_req(FUNC_CPU_READ, 16'hA000, 8'h00);
    send_req(FUNC_CPU_READ, 16'hC000, 8'h00);
    send_req(FUNC_CPU_READ, 16'hFFFF, 8'h00);
    // Swap mode moves the second-last bank to 0x8000.
    send_req(FUNC_CPU_WRITE, 16'h9002, 8'h02);
    send_req(FUNC_CPU_READ, 16'h9FFF, 8'h00);
    send_req(FUNC_CPU_READ, 16'hDFFF, 8'h00);
    send_req(FUNC_CPU_WRITE, 16'h9000, 8'h03);
    send_req(FUNC_CPU_WRITE, 16'h8000, 8'hFF);
    send_req(FUNC_CPU_WRITE, 16'hB000, 8'hFF);
    send_req(FUNC_CPU_WRITE, 16'hB001, 8'hFF);
    send_req(FUNC_PPU_ACCESS, 16'h0000, 8'h00);
    send_req(FUNC_PPU_ACCESS, 16'h1FFF, 8'h00);
    send_req(FUNC_PPU_ACCESS, 16'h2000, 8'h00);
    // Cycle mode from a latch of 0xFE overflows on the second tick.
    send_req(FUNC_CPU_WRITE, 16'hF000, 8'h0E);
    send_req(FUNC_CPU_WRITE, 16'hF001, 8'hFF);
    send_req(FUNC_CPU_WRITE, 16'hF002, 8'h06);
    send_req(FUNC_M2_TICK, 16'hFFFF, 8'hFF);
    send_req(FUNC_M2_TICK, 16'h0000, 8'h00);
    send_req(FUNC_CPU_WRITE, 16'hF003, 8'h00);
  endtask

  task automatic set_bank_config(input int phase);
    case (phase)
      1: begin
        write_cfg(CFG_PRG_BANK_COUNT, 10'd0);
        write_cfg(CFG_CHR_BANK_COUNT, 10'd0);
        write_cfg(CFG_PRG_RAM_PRESENT, 10'd0);
      end
      2: begin
        write_cfg(CFG_PRG_BANK_COUNT, 10'd1);
        write_cfg(CFG_CHR_BANK_COUNT, 10'd1);
        write_cfg(CFG_PRG_RAM_PRESENT, 10'd1);
      end
      3: begin
        write_cfg(CFG_PRG_BANK_COUNT, 10'd256);
        write_cfg(CFG_CHR_BANK_COUNT, 10'd512);
      end
      4: begin
        write_cfg(CFG_PRG_BANK_COUNT, 10'd2);
        write_cfg(CFG_CHR_BANK_COUNT, 10'd3);
        write_cfg(CFG_PRG_RAM_PRESENT, 10'd0);
      end
      default: begin
        write_cfg(CFG_PRG_BANK_COUNT, 10'($urandom_range(0, 256)));
        write_cfg(CFG_CHR_BANK_COUNT, 10'($urandom_range(0, 512)));
        write_cfg(CFG_PRG_RAM_PRESENT, 10'($urandom_range(0, 1)));
      end
    endcase
  endtask

  initial begin : stimulus
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_PRG_BANK_COUNT;
    cfg_data_i = 10'd0;
    in_valid_i = 1'b0;
    func_i     = FUNC_CPU_READ;
    addr_i     = 16'h0000;
    data_i     = 8'h00;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    directed_requests();
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        drain();
        set_bank_config(phase);
      end
      // Phase two has the long receiver hold-off, phase three runs without gaps.
      if (phase == 2) hold_req = 1'b1;
      calm      = (phase == 3);
      phase_end = sent_cnt + PHASE_REQUESTS;
      while (sent_cnt < phase_end) random_request();
    end
    calm = 1'b0;

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_count == 0)
      $display("cartridge_bank_mapper_with_irq: match");
    else
      $display("cartridge_bank_mapper_with_irq: mismatch");
    $finish;
  end

endmodule
